// ===== hw/rtl/iaf_pkg.sv =====
`default_nettype none

package iaf_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int MAX_WIDTH   = 64;
  localparam int DIGIT_SLOTS = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int FIELD_W = 7;
  localparam int BASE_W  = 2;
  localparam int CHAR_W  = 8;

  localparam int CW_W     = $clog2(MAX_WIDTH + 1);
  localparam int LEN_W    = $clog2(MAX_WIDTH + DIGIT_SLOTS + 2);
  localparam int DIG_IW   = $clog2(DIGIT_SLOTS);
  localparam int SHIFT_W  = $clog2(VALUE_BITS + 1);
  localparam int QP_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int PAD_BITS = 4 * DIGIT_SLOTS;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;

  localparam int OCT_TOP = ((OCT_DIGITS < DIGIT_SLOTS) ? OCT_DIGITS : DIGIT_SLOTS) - 1;
  localparam int DEC_TOP = ((DEC_DIGITS < DIGIT_SLOTS) ? DEC_DIGITS : DIGIT_SLOTS) - 1;
  localparam int HEX_TOP = ((HEX_DIGITS < DIGIT_SLOTS) ? HEX_DIGITS : DIGIT_SLOTS) - 1;

  localparam logic [BASE_W-1:0] BASE_OCT = 2'd0;
  localparam logic [BASE_W-1:0] BASE_DEC = 2'd1;
  localparam logic [BASE_W-1:0] BASE_HEX = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    radix_t                radix;
    logic                  upper;
    logic                  neg;
    logic [CW_W-1:0]       width;
    logic                  zpad;
    logic [CW_W-1:0]       room;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return base + CHAR_W'(d) - CHAR_W'(10);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iaf_front.sv =====
`default_nettype none

module iaf_front import iaf_pkg::*; (
  input  wire logic               start,
  input  wire logic               q_full,
  input  wire logic [63:0]        in_value,
  input  wire logic [BASE_W-1:0]  in_base_code,
  input  wire logic               in_upper_case,
  input  wire logic               in_negative,
  input  wire logic [FIELD_W-1:0] in_field_width,
  input  wire logic               in_zero_pad,
  input  wire logic [FIELD_W-1:0] in_room,
  output logic                    busy,
  output logic                    push,
  output job_t                    job
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    job.mag   = in_value[VALUE_BITS-1:0];
    job.upper = in_upper_case;
    job.neg   = in_negative;
    job.zpad  = in_zero_pad;
    unique case (in_base_code)
      BASE_OCT: job.radix = RADIX_OCT;
      BASE_DEC: job.radix = RADIX_DEC;
      BASE_HEX: job.radix = RADIX_HEX;
      default:  job.radix = RADIX_HEX;
    endcase
    job.width = (in_field_width > FIELD_W'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH)
                                                       : CW_W'(in_field_width);
    job.room  = (in_room > FIELD_W'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH) : CW_W'(in_room);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iaf_queue.sv =====
`default_nettype none

module iaf_queue import iaf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      rd_job,
  output logic      full,
  output logic      empty
);

  job_t            q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iaf_back.sv =====
`default_nettype none

module iaf_back import iaf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire job_t         job,
  input  wire logic         empty,
  output logic              pop,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [3:0]            dig_r [DIGIT_SLOTS];
  logic [VALUE_BITS-1:0] sh_r;
  logic [SHIFT_W-1:0]    cnt_r;
  logic [DIG_IW-1:0]     idx_r;
  radix_t                radix_r;
  logic                  upper_r;
  logic                  neg_r;
  logic                  zpad_r;
  logic [CW_W-1:0]       width_r;
  logic [CW_W-1:0]       room_r;
  logic [LEN_W-1:0]      padn_r;
  logic [LEN_W-1:0]      pos_r;
  logic [LEN_W-1:0]      rem_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [PAD_BITS-1:0]   magx;
  logic [3:0]            dd_nxt [DEC_DIGITS];
  logic [3:0]            adj;
  logic                  carry;
  logic                  found;
  logic [LEN_W-1:0]      nd;
  logic [LEN_W-1:0]      textlen;
  logic [LEN_W-1:0]      wid;
  logic [LEN_W-1:0]      padn_calc;
  logic [LEN_W-1:0]      line_len;
  logic [LEN_W-1:0]      total_calc;
  logic [LEN_W-1:0]      padn_neg;
  logic [CHAR_W-1:0]     ch;
  logic                  is_dig;
  logic [DIG_IW-1:0]     top_idx;

  assign pop  = (state_r == ST_IDLE) && !empty;
  assign magx = PAD_BITS'(job.mag);

  always_comb begin
    unique case (job.radix)
      RADIX_OCT: top_idx = DIG_IW'(OCT_TOP);
      RADIX_DEC: top_idx = DIG_IW'(DEC_TOP);
      RADIX_HEX: top_idx = DIG_IW'(HEX_TOP);
      default:   top_idx = DIG_IW'(HEX_TOP);
    endcase
  end

  // double dabble step, one value bit per cycle
  always_comb begin
    carry = sh_r[VALUE_BITS-1];
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj       = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
      dd_nxt[i] = {adj[2:0], carry};
      carry     = adj[3];
    end
  end

  // length of the padded line once the top digit is known
  always_comb begin
    found      = (dig_r[idx_r] != 4'd0) || (idx_r == '0);
    nd         = LEN_W'(idx_r) + 1'b1;
    textlen    = nd + LEN_W'(neg_r);
    wid        = LEN_W'(width_r);
    padn_calc  = (wid > textlen) ? wid - textlen : '0;
    line_len   = padn_calc + textlen;
    total_calc = (line_len > LEN_W'(room_r)) ? LEN_W'(room_r) : line_len;
  end

  always_comb begin
    padn_neg = padn_r + LEN_W'(neg_r);
    ch       = digit_char(dig_r[idx_r], upper_r);
    is_dig   = 1'b0;
    if (zpad_r) begin
      priority if (neg_r && pos_r == '0) begin
        ch = CH_MINUS;
      end else if (pos_r < padn_neg) begin
        ch = CH_ZERO;
      end else begin
        is_dig = 1'b1;
      end
    end else begin
      priority if (pos_r < padn_r) begin
        ch = CH_SPACE;
      end else if (neg_r && pos_r == padn_r) begin
        ch = CH_MINUS;
      end else begin
        is_dig = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          state_nxt = (job.radix == RADIX_DEC) ? ST_CONV : ST_SCAN;
        end
      end
      ST_CONV: begin
        if (cnt_r == SHIFT_W'(1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_nxt = (total_calc == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rem_r == LEN_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= ch;
    out_last_r <= (rem_r == LEN_W'(1));
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          radix_r <= job.radix;
          upper_r <= job.upper;
          neg_r   <= job.neg;
          zpad_r  <= job.zpad;
          width_r <= job.width;
          room_r  <= job.room;
          sh_r    <= job.mag;
          cnt_r   <= SHIFT_W'(VALUE_BITS);
          idx_r   <= top_idx;
          for (int i = 0; i < DIGIT_SLOTS; i++) begin
            unique case (job.radix)
              RADIX_OCT: dig_r[i] <= {1'b0, magx[3*i +: 3]};
              RADIX_DEC: dig_r[i] <= 4'd0;
              RADIX_HEX: dig_r[i] <= magx[4*i +: 4];
              default:   dig_r[i] <= magx[4*i +: 4];
            endcase
          end
        end
      end
      ST_CONV: begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
          dig_r[i] <= dd_nxt[i];
        end
        sh_r  <= {sh_r[VALUE_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_SCAN: begin
        if (found) begin
          padn_r <= padn_calc;
          rem_r  <= total_calc;
          pos_r  <= '0;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
      ST_EMIT: begin
        pos_r <= pos_r + 1'b1;
        rem_r <= rem_r - 1'b1;
        if (is_dig && idx_r != '0) begin
          idx_r <= idx_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_EMIT)
    else $error("character strobe without emit cycle");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("character after last of transaction");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> rem_r != '0)
    else $error("emit with no characters left");

  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && radix_r == RADIX_DEC) |-> dig_r[idx_r] <= 4'd9)
    else $error("decimal digit out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
`default_nettype none

// integer to ascii formatter
// input: a transaction is taken on a rising edge with start high and busy low;
//   in_value is converted in octal, decimal or hex (base code three means hex),
//   padded to in_field_width and cut to in_room characters.
// output: one character per strobe on out_valid, most significant first;
//   out_last marks the final character of a transaction. a room of zero
//   gives no characters. the receiver cannot stall: every strobe is taken.
// a two-entry queue parts the accepting front from the converting back end,
//   so busy rises only when both queued transactions wait.
// steps per transaction in the back end: a pop that loads the job, then
//   hex and octal: digits are taken straight from the value bits,
//   decimal: shift-add-3 over every value bit, one value bit per cycle,
//   then a scan of the digit positions from the top slot of the radix
//   (22 octal, 20 decimal, 16 hex) down to the leading digit,
//   then the characters are emitted (up to 64).
// the first character appears in the cycle after its emit cycle (output register).
// the back end takes one transaction at a time; the queue takes new ones meanwhile.
// reset: synchronous active-low rst_n empties the queue and idles the back end.

module integer_to_ascii_formatter import iaf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [63:0]        in_value,
  input  wire logic [BASE_W-1:0]  in_base_code,
  input  wire logic               in_upper_case,
  input  wire logic               in_negative,
  input  wire logic [FIELD_W-1:0] in_field_width,
  input  wire logic               in_zero_pad,
  input  wire logic [FIELD_W-1:0] in_room,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       out_character,
  output logic                    out_last
);

  job_t wr_job;
  job_t rd_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  iaf_front u_front (
    .start          (start),
    .q_full         (q_full),
    .in_value       (in_value),
    .in_base_code   (in_base_code),
    .in_upper_case  (in_upper_case),
    .in_negative    (in_negative),
    .in_field_width (in_field_width),
    .in_zero_pad    (in_zero_pad),
    .in_room        (in_room),
    .busy           (busy),
    .push           (push),
    .job            (wr_job)
  );

  iaf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  iaf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (rd_job),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
